/* design/life_cell_automaton_step_macros.svh */
// Assertion macros for the Game of Life stream step: implication checks on one
// clock edge and on the next. Depends on nothing; empty when SYNTHESIS is defined.
`ifndef LIFE_CELL_AUTOMATON_STEP_MACROS_SVH
`define LIFE_CELL_AUTOMATON_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define LCAS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define LCAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCAS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define LCAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/lcas_pkg.sv */
// Shared types, constants and the B3/S23 rule for the Game of Life stream step.
// Depends on nothing; used by the interfaces' users, the line store and the result queue.
package lcas_pkg;

  localparam int unsigned MAX_COLS_DEF   = 48;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned ROWCNT_W       = 13;
  localparam int unsigned COLCNT_W       = 6;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned RES_FIFO_DEPTH = 8;
  localparam int unsigned RES_ROOM       = 4;

  localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 13'd40;
  localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 6'd40;
  localparam logic [ROWCNT_W-1:0] ROW_LIMIT     = 13'd4096;

  typedef enum logic [0:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_STREAM = 1'b0,
    ST_FLUSH  = 1'b1
  } flush_state_e;

  typedef struct packed {
    logic middle;
    logic upper;
  } line_t;

  typedef struct packed {
    logic next_alive;
    logic end_of_generation;
    logic last_in_run;
  } res_t;

  // Next state of the center cell (bit 4) of a 3x3 window.
  function automatic logic judge(input logic [8:0] win);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) begin
        n = n + 4'(win[b]);
      end
    end
    return (n == 4'd3) || ((n == 4'd2) && win[4]);
  endfunction

endpackage

/* design/lcas_in_if.sv */
// Cell request channel into the Game of Life stream step: valid, ready, alive bit.
// Depends on nothing.
interface lcas_in_if;
  logic valid;
  logic ready;
  logic alive;

  modport source (output valid, output alive, input ready);
  modport sink (input valid, input alive, output ready);
endinterface

/* design/lcas_out_if.sv */
// Result request channel out of the Game of Life stream step.
// Depends on nothing.
interface lcas_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic end_of_generation;
  logic last_in_run;

  modport source (output valid, output next_alive, output end_of_generation,
                  output last_in_run, input ready);
  modport sink (input valid, input next_alive, input end_of_generation,
                input last_in_run, output ready);
endinterface

/* design/lcas_line_mem.sv */
// Line store: rows r-2 and r-1 per column, synchronous read, write-first bypass.
// Per-entry valid flops make unwritten entries read as dead. Depends on lcas_pkg.
module lcas_line_mem import lcas_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [$clog2(MAX_COLS)-1:0] rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_COLS)-1:0] wr_addr_i,
  input  line_t                       wr_data_i,
  output line_t                       rd_data_o
);

  line_t               mem_q [MAX_COLS];
  logic [MAX_COLS-1:0] vld_q;
  line_t               rd_raw_q;
  line_t               byp_data_q;
  logic                byp_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_raw_q   <= mem_q[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      byp_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      byp_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (rd_vld_q ? rd_raw_q : '0);

endmodule

/* design/lcas_res_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one a cycle.
// Depends on lcas_pkg.
module lcas_res_fifo import lcas_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_cnt_i,
  input  res_t                                push0_i,
  input  res_t                                push1_i,
  input  logic                                pop_i,
  output res_t                                head_o,
  output logic [$clog2(RES_FIFO_DEPTH+1)-1:0] cnt_o
);

  localparam int unsigned PW = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(RES_FIFO_DEPTH + 1);

  res_t          ent_q [RES_FIFO_DEPTH];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] wp_d;
  logic [PW-1:0] wp_nx;
  logic [PW-1:0] rp_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_d;

  assign wp_nx = wp_q + 1'b1;

  always_comb begin
    wp_d  = wp_q + PW'(push_cnt_i);
    cnt_d = cnt_q + CW'(push_cnt_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      ent_q[wp_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_q[wp_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  assign head_o = ent_q[rp_q];
  assign cnt_o  = cnt_q;

endmodule

/* design/life_cell_automaton_step.sv */
// Game of Life (B3/S23) generation step over a raster cell stream. One cell is taken
// per clock while streaming; the result for cell (r-1,c-1) leaves with cell (r,c), and
// the end of each row adds the row's last result. After the last cell of a generation
// the block takes no cell while it reads the line store one column per cycle (when the
// queue has room) to flush the last row through its single read port. Results wait in
// an 8-entry queue and leave at one per cycle while the receiver is ready; cells stall
// when that queue backs up and during the flush. The line store needs no clearing pass
// after reset. Depends on lcas_pkg, lcas_in_if, lcas_out_if, lcas_line_mem and lcas_res_fifo.
`include "life_cell_automaton_step_macros.svh"

module life_cell_automaton_step import lcas_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcas_in_if.sink               cell_in,
  lcas_out_if.source            cell_out,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned FK_W  = $clog2(MAX_COLS + 1);
  localparam int unsigned CW    = $clog2(RES_FIFO_DEPTH + 1);
  localparam logic [COLCNT_W:0] MAX_COLS_V = (COLCNT_W + 1)'(MAX_COLS);

  typedef struct packed {
    logic             flush;
    logic             alive;
    logic [COL_W-1:0] addr;
    logic             row0;
    logic             col0;
    logic             row_end;
    logic             frame_end;
    logic             k_first;
    logic             dead;
  } stage_t;

  logic [ROWCNT_W-1:0] row_count_q;
  logic [COLCNT_W-1:0] col_count_q;
  logic [ROW_W-1:0]    rows_m1;
  logic [COL_W-1:0]    cols_m1;
  logic [FK_W-1:0]     cols_fk;

  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic                row_end;
  logic                frame_end;

  flush_state_e        state_q;
  flush_state_e        state_d;
  logic [FK_W-1:0]     fk_q;
  logic [FK_W-1:0]     fk_d;
  logic                in_ready;
  logic                tok_issue;
  logic                accept;
  logic                room;

  stage_t              s1_d;
  stage_t              s1_q;
  logic                s1_vld_d;
  logic                s1_vld_q;

  line_t               line_rd;
  line_t               line_wd;
  logic                line_we;
  logic                top_bit;
  logic [2:0]          new_col;
  logic [8:0]          win_d;
  logic [8:0]          win_q;
  logic [1:0]          fcol;
  logic [5:0]          fwin_d;
  logic [5:0]          fwin_q;
  logic [8:0]          fwin9;
  logic                va;
  logic                vb;
  res_t                res_a;
  res_t                res_b;
  res_t                res_f;
  logic [1:0]          push_cnt;
  res_t                push0;
  res_t                push1;

  res_t                head;
  logic [CW-1:0]       fifo_cnt;
  logic                pop;

  // Clamp the configured counts.
  always_comb begin
    if (row_count_q == '0) begin
      rows_m1 = '0;
    end else if (row_count_q >= ROW_LIMIT) begin
      rows_m1 = ROW_W'(ROW_LIMIT - 1'b1);
    end else begin
      rows_m1 = ROW_W'(row_count_q - 1'b1);
    end
    if (col_count_q == '0) begin
      cols_m1 = '0;
    end else if ({1'b0, col_count_q} > MAX_COLS_V) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(col_count_q - 1'b1);
    end
    cols_fk = FK_W'(cols_m1) + FK_W'(1);
  end

  assign row_end   = col_q >= cols_m1;
  assign frame_end = row_end && (row_q >= rows_m1);
  assign room      = fifo_cnt <= CW'(RES_FIFO_DEPTH - RES_ROOM);
  assign accept    = cell_in.valid && in_ready;
  assign cell_in.ready = in_ready;

  always_comb begin
    state_d   = state_q;
    fk_d      = fk_q;
    in_ready  = 1'b0;
    tok_issue = 1'b0;
    case (state_q)
      ST_STREAM: begin
        in_ready = room;
        if (cell_in.valid && room && frame_end) begin
          state_d = ST_FLUSH;
          fk_d    = '0;
        end
      end
      ST_FLUSH: begin
        if (room) begin
          tok_issue = 1'b1;
          fk_d      = fk_q + 1'b1;
          if (fk_q == cols_fk) begin
            state_d = ST_STREAM;
          end
        end
      end
      default: begin
        state_d = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STREAM;
      fk_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      s1_vld_q    <= 1'b0;
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else begin
      state_q  <= state_d;
      fk_q     <= fk_d;
      s1_vld_q <= s1_vld_d;
      if (accept) begin
        if (frame_end) begin
          row_q <= '0;
          col_q <= '0;
        end else if (row_end) begin
          row_q <= row_q + 1'b1;
          col_q <= '0;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_COUNT: row_count_q <= cfg_data_i[ROWCNT_W-1:0];
          CFG_COL_COUNT: col_count_q <= cfg_data_i[COLCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Issue stage: a cell or a flush column, read address goes to the line store.
  always_comb begin
    s1_d     = '0;
    s1_vld_d = accept || tok_issue;
    if (tok_issue) begin
      s1_d.flush   = 1'b1;
      s1_d.k_first = fk_q == '0;
      s1_d.dead    = fk_q == cols_fk;
      s1_d.addr    = (fk_q == cols_fk) ? '0 : COL_W'(fk_q);
    end else begin
      s1_d.alive     = cell_in.alive;
      s1_d.addr      = col_q;
      s1_d.row0      = row_q == '0;
      s1_d.col0      = col_q == '0;
      s1_d.row_end   = row_end;
      s1_d.frame_end = frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (s1_vld_q && !s1_q.flush) begin
      win_q <= win_d;
    end
    if (s1_vld_q && s1_q.flush) begin
      fwin_q <= fwin_d;
    end
  end

  lcas_line_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (s1_d.addr),
    .wr_en_i   (line_we),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (line_wd),
    .rd_data_o (line_rd)
  );

  // Judge stage: shift the window, write the line back, form results.
  always_comb begin
    top_bit        = s1_q.row0 ? 1'b0 : line_rd.upper;
    new_col        = {s1_q.alive, line_rd.middle, top_bit};
    win_d          = s1_q.col0 ? {new_col, 6'b0} : {new_col, win_q[8:3]};
    line_we        = s1_vld_q && !s1_q.flush;
    line_wd.middle = s1_q.alive;
    line_wd.upper  = s1_q.row0 ? 1'b0 : line_rd.middle;

    fcol   = s1_q.dead ? 2'b00 : {line_rd.middle, line_rd.upper};
    fwin_d = s1_q.k_first ? {fcol, 4'b0} : {fcol, fwin_q[5:2]};
    fwin9  = {1'b0, fwin_d[5:4], 1'b0, fwin_d[3:2], 1'b0, fwin_d[1:0]};

    va = !s1_q.row0 && !s1_q.col0;
    vb = !s1_q.row0 && s1_q.row_end;

    res_a = '{next_alive: judge(win_d), end_of_generation: 1'b0,
              last_in_run: !s1_q.row_end};
    res_b = '{next_alive: judge({3'b000, win_d[8:3]}), end_of_generation: 1'b0,
              last_in_run: !s1_q.frame_end};
    res_f = '{next_alive: judge(fwin9), end_of_generation: s1_q.dead,
              last_in_run: s1_q.dead};

    push_cnt = 2'd0;
    push0    = res_b;
    push1    = res_b;
    if (s1_vld_q) begin
      if (s1_q.flush) begin
        push_cnt = {1'b0, !s1_q.k_first};
        push0    = res_f;
      end else begin
        push_cnt = 2'(va) + 2'(vb);
        push0    = va ? res_a : res_b;
      end
    end
  end

  lcas_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .pop_i      (pop),
    .head_o     (head),
    .cnt_o      (fifo_cnt)
  );

  assign cell_out.valid             = fifo_cnt != '0;
  assign cell_out.next_alive        = head.next_alive;
  assign cell_out.end_of_generation = head.end_of_generation;
  assign cell_out.last_in_run       = head.last_in_run;
  assign pop = cell_out.valid && cell_out.ready;

  `LCAS_ASSERT_IMPLY(a_fifo_bound, clk_i, rst_ni, 1'b1, fifo_cnt <= CW'(RES_FIFO_DEPTH), "result queue overflow")
  `LCAS_ASSERT_NEXT(a_flush_start, clk_i, rst_ni, accept && frame_end, state_q == ST_FLUSH && fk_q == '0, "flush did not start after last cell")
  `LCAS_ASSERT_IMPLY(a_flush_single, clk_i, rst_ni, s1_vld_q && s1_q.flush, push_cnt <= 2'd1 && !line_we, "flush column pushed two results or wrote the line store")

endmodule
